FILE: src/sbda_pkg.sv
`timescale 1ns / 1ps
// sbda_pkg: widths and character codes for the signed binary to decimal ascii unit
// no dependencies

package sbda_pkg;

    // width of the signed input value (range 4 to 64)
    localparam int VALUE_WIDTH = 32;

    // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int DIGIT_COUNT = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = DIGIT_COUNT * 4;

    // stream data widths, rounded up to whole bytes
    localparam int TDATA_IN_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CHAR_WIDTH     = 8;

    // counters
    localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int DIGIT_CNT_WIDTH = $clog2(DIGIT_COUNT + 1);

    // ascii codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'd57;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'd45;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 8'd10;

endpackage

FILE: src/signed_binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// signed_binary_to_decimal_ascii_unit: renders a signed integer as decimal ascii text
// depends on sbda_pkg (widths, ascii codes)
//
// channel   dir  width                   contents
// s_axis    in   sbda_pkg::TDATA_IN_WIDTH value (signed, lowest bits), zero padded
// m_axis    out  8 + tlast               character, tlast on the closing newline
//
// sequence: an accept in idle, the bit-serial double-dabble loop over every input
// bit, a skip step per leading zero digit plus a closing one, then the characters
// one at a time as the output register frees
// reset: rst_n asynchronous, active low, returns to idle with no output pending
// stalls: a low m_axis_tready freezes the character sequencer; the last
// character sits in the output register while the next value is taken

module signed_binary_to_decimal_ascii_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sbda_pkg::TDATA_IN_WIDTH-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] value

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sbda_pkg::CHAR_WIDTH-1:0]     m_axis_tdata,   // [7:0] character
    output logic                                m_axis_tlast    // last_char
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_NL
    } state_t;

    state_t                                 state_reg;
    logic [sbda_pkg::VALUE_WIDTH-1:0]       mag_reg;      // magnitude, shifted out msb first
    logic [sbda_pkg::BCD_WIDTH-1:0]         bcd_reg;      // packed bcd digits, most significant on top
    logic [sbda_pkg::BCD_WIDTH-1:0]         bcd_next;
    logic                                   neg_reg;
    logic [sbda_pkg::BIT_CNT_WIDTH-1:0]     bit_cnt_reg;
    logic [sbda_pkg::DIGIT_CNT_WIDTH-1:0]   digit_cnt_reg; // digits still in bcd_reg
    logic                                   out_valid_reg;
    logic [sbda_pkg::CHAR_WIDTH-1:0]        out_char_reg;
    logic                                   out_last_reg;

    logic [sbda_pkg::VALUE_WIDTH-1:0]       in_value;
    logic                                   in_neg;
    logic [3:0]                             top_digit;
    logic                                   out_load;     // output register free this cycle
    logic                                   char_emit;    // a character enters the output register
    logic                                   in_accept;

    assign in_value  = s_axis_tdata[sbda_pkg::VALUE_WIDTH-1:0];
    assign in_neg    = in_value[sbda_pkg::VALUE_WIDTH-1];
    assign top_digit = bcd_reg[sbda_pkg::BCD_WIDTH-1 -: 4];
    assign out_load  = !out_valid_reg || m_axis_tready;
    assign char_emit = out_load && (state_reg inside {ST_SIGN, ST_DIGIT, ST_NL});

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // double-dabble step: add 3 to every digit of 5 or more, then shift in the next bit
    always_comb
    begin
        logic [sbda_pkg::BCD_WIDTH-1:0] corr;
        logic [3:0]                     d;
        corr = '0;
        d    = '0;
        for (int i = 0; i < sbda_pkg::DIGIT_COUNT; i++)
        begin
            d = bcd_reg[4*i +: 4];
            corr[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        bcd_next = {corr[sbda_pkg::BCD_WIDTH-2:0], mag_reg[sbda_pkg::VALUE_WIDTH-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            neg_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // a taken character leaves unless a new one replaces it
            if (char_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        // the most negative value negates to 2^(VALUE_WIDTH-1) unsigned
                        mag_reg     <= in_neg ? (~in_value + 1'b1) : in_value;
                        neg_reg     <= in_neg;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= sbda_pkg::BIT_CNT_WIDTH'(sbda_pkg::VALUE_WIDTH - 1);
                        state_reg   <= ST_CONV;
                    end
                end

                ST_CONV:
                begin
                    bcd_reg <= bcd_next;
                    mag_reg <= mag_reg << 1;
                    if (bit_cnt_reg == '0)
                    begin
                        digit_cnt_reg <= sbda_pkg::DIGIT_CNT_WIDTH'(sbda_pkg::DIGIT_COUNT);
                        state_reg     <= ST_SKIP;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end

                ST_SKIP:
                begin
                    // drop leading zeros but keep at least one digit
                    if (top_digit == 4'd0 && digit_cnt_reg > sbda_pkg::DIGIT_CNT_WIDTH'(1))
                    begin
                        bcd_reg       <= bcd_reg << 4;
                        digit_cnt_reg <= digit_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                end

                ST_SIGN:
                begin
                    if (out_load)
                    begin
                        out_char_reg  <= sbda_pkg::CHAR_MINUS;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_DIGIT;
                    end
                end

                ST_DIGIT:
                begin
                    if (out_load)
                    begin
                        out_char_reg  <= sbda_pkg::CHAR_ZERO + {4'b0000, top_digit};
                        out_last_reg  <= 1'b0;
                        bcd_reg       <= bcd_reg << 4;
                        digit_cnt_reg <= digit_cnt_reg - 1'b1;
                        if (digit_cnt_reg == sbda_pkg::DIGIT_CNT_WIDTH'(1))
                        begin
                            state_reg <= ST_NL;
                        end
                    end
                end

                ST_NL:
                begin
                    if (out_load)
                    begin
                        out_char_reg  <= sbda_pkg::CHAR_NEWLINE;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // one value at a time: the converter is busy right after taking a value
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("value accepted while conversion still running");

    // only the newline closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == sbda_pkg::CHAR_NEWLINE))
    else $error("last character is not a newline");

    // every other character is a minus sign or a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        ((m_axis_tdata == sbda_pkg::CHAR_MINUS) ||
         ((m_axis_tdata >= sbda_pkg::CHAR_ZERO) && (m_axis_tdata <= sbda_pkg::CHAR_NINE))))
    else $error("unexpected character in run");

    // the digit sequencer never runs out of digits before the newline
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (digit_cnt_reg != '0))
    else $error("digit count exhausted while emitting digits");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for signed_binary_to_decimal_ascii_unit, one value in, text out
// depends on sbda_pkg (widths, ascii codes) and the unit itself

module testbench;

    import sbda_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 430;
    localparam int PHASE_COUNT   = 5;
    // a negative value yields up to 12 characters, while in the receiver stalling
    // phase the receiver holds off 79 percent of the time
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int RADIX         = 10;

    // one value waiting to be offered, along with the idling it is offered under
    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        int                     idle_pct;
        int                     stall_pct;
        bit                     wait_drained;
    } pending_value_t;

    // one character the unit should produce
    typedef struct {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last_char;
    } text_char_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [TDATA_IN_WIDTH-1:0] s_axis_tdata;   // [VALUE_WIDTH-1:0] value
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [CHAR_WIDTH-1:0]     m_axis_tdata;   // [7:0] character
    logic                      m_axis_tlast;   // last_char

    pending_value_t values_to_send[$];
    text_char_t     expected_text[$];

    // set at the rising edge of an input transaction, consumed at the next falling edge
    bit value_taken;
    int stall_pct_now;
    int error_count;
    int cycle_count;
    int values_accepted;
    int negative_accepted;
    int chars_checked;

    signed_binary_to_decimal_ascii_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF_NS clk = ~clk;

    // renders one value as decimal text and appends the characters to the expected store:
    // optional minus sign, digits most significant first, closing newline marked last
    function automatic void render_decimal_text(input logic [VALUE_WIDTH-1:0] value);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [3:0]             digits[$];
        text_char_t             entry;
        negative = value[VALUE_WIDTH-1];
        // the most negative value negates onto itself, which read unsigned is the exact magnitude
        magnitude = negative ? (~value + 1'b1) : value;
        // zero still yields a single digit
        do
        begin
            digits.push_front(4'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end
        while (magnitude != 0);
        if (negative)
        begin
            entry.character = CHAR_MINUS;
            entry.last_char = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[i])
        begin
            entry.character = CHAR_ZERO + digits[i];
            entry.last_char = 1'b0;
            expected_text.push_back(entry);
        end
        entry.character = CHAR_NEWLINE;
        entry.last_char = 1'b1;
        expected_text.push_back(entry);
    endfunction

    // random value with a bias toward every digit count and the edges between them
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        longint pow10;
        longint magnitude;
        int     digit_count;
        int     pick;
        pow10 = 1;
        pick = $urandom_range(99);
        digit_count = $urandom_range(1, 10);
        for (int i = 0; i < digit_count; i++)
        begin
            pow10 = pow10 * RADIX;
        end
        if (pick < 35)
        begin
            // full range, every bit random
            magnitude = longint'({$urandom, $urandom});
        end
        else if (pick < 75)
        begin
            // uniform within a chosen digit count
            magnitude = longint'({1'b0, $urandom, $urandom} % pow10);
        end
        else if (pick < 95)
        begin
            // straddling a power of ten
            magnitude = pow10 + $urandom_range(0, 2) - 1;
        end
        else
        begin
            // near the ends of the range
            magnitude = (64'sd1 <<< (VALUE_WIDTH - 1)) - $urandom_range(0, 2);
        end
        if ($urandom_range(1))
        begin
            magnitude = -magnitude;
        end
        return VALUE_WIDTH'(magnitude);
    endfunction

    task automatic queue_value(input logic [VALUE_WIDTH-1:0] value, input int idle_pct,
                               input int stall_pct, input bit wait_drained);
        pending_value_t item;
        item.value        = value;
        item.idle_pct     = idle_pct;
        item.stall_pct    = stall_pct;
        item.wait_drained = wait_drained;
        values_to_send.push_back(item);
    endtask

    // monitor: samples both channels at the rising edge, predicts on input transactions,
    // checks output transactions against the oldest expected character
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            render_decimal_text(s_axis_tdata[VALUE_WIDTH-1:0]);
            values_accepted++;
            if (s_axis_tdata[VALUE_WIDTH-1])
            begin
                negative_accepted++;
            end
            value_taken = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character: actual character 'h%02h last_char %0b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (m_axis_tdata !== want.character)
                begin
                    $error("character mismatch: expected 'h%02h actual 'h%02h",
                           want.character, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_char)
                begin
                    $error("last_char mismatch: expected %0b actual %0b",
                           want.last_char, m_axis_tlast);
                    error_count++;
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, expected_text.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: moves inputs at the falling edge; a valid value is held until taken,
    // otherwise the next one is offered unless the sender idles or waits for a drain
    always @(negedge clk)
    begin
        pending_value_t item;
        if (rst_n)
        begin
            if (!s_axis_tvalid || value_taken)
            begin
                value_taken = 1'b0;
                if (values_to_send.size() != 0
                    && !(values_to_send[0].wait_drained && expected_text.size() != 0)
                    && $urandom_range(99) >= values_to_send[0].idle_pct)
                begin
                    item = values_to_send.pop_front();
                    stall_pct_now = item.stall_pct;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= TDATA_IN_WIDTH'(item.value);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct_now);
        end
    end

    // stimulus and end of run
    initial
    begin
        int idle_of_phase[PHASE_COUNT];
        int stall_of_phase[PHASE_COUNT];
        int per_phase;
        clk               = 1'b0;
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        m_axis_tready     = 1'b0;
        value_taken       = 1'b0;
        stall_pct_now     = 0;
        error_count       = 0;
        cycle_count       = 0;
        values_accepted   = 0;
        negative_accepted = 0;
        chars_checked     = 0;

        // no idling, sender idle, receiver stalling, both, and a last stretch with none
        idle_of_phase  = '{0, 79, 0, 18, 0};
        stall_of_phase = '{0, 0, 79, 18, 0};

        // directed: zero, one digit, powers of ten, both ends, alternating bit patterns
        queue_value(VALUE_WIDTH'(0), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(1), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-1), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(9), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(10), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-10), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(42), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-7), 0, 0, 1'b0);
        // most positive, most negative and its neighbor
        queue_value({1'b0, {(VALUE_WIDTH-1){1'b1}}}, 0, 0, 1'b0);
        queue_value({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 0, 0, 1'b0);
        queue_value({1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1}, 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(1000000000), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(999999999), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-999999999), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-1000000000), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(1234567890), 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(-1234567890), 0, 0, 1'b0);
        queue_value({(VALUE_WIDTH/2){2'b01}}, 0, 0, 1'b0);
        queue_value({(VALUE_WIDTH/2){2'b10}}, 0, 0, 1'b0);
        // zero right after the most negative value
        queue_value({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 0, 0, 1'b0);
        queue_value(VALUE_WIDTH'(0), 0, 0, 1'b0);

        // random phases; each starts from a drained unit, and a few values mid-phase
        // also wait for every pending character before they go out
        per_phase = RANDOM_ITEMS / PHASE_COUNT;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            for (int i = 0; i < per_phase; i++)
            begin
                queue_value(random_value(), idle_of_phase[p], stall_of_phase[p],
                            (i == 0) || ($urandom_range(99) < 2));
            end
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // every value taken, every character seen, then a quiet tail for strays
        wait (values_to_send.size() == 0 && !s_axis_tvalid);
        wait (expected_text.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d values (%0d negative) into %0d checked characters",
                 values_accepted, negative_accepted, chars_checked);
        $display("idling phases: none, sender 79%%, receiver 79%%, both 18%%, none again");
        if (error_count == 0 && expected_text.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/sbda_pkg.sv
src/signed_binary_to_decimal_ascii_unit.sv
tb/sv/testbench.sv
